FILE: hw/rtl/hirb_pkg.sv
// ----------------------------------------------------------------------------
// hirb_pkg
// Shared codes, request and report types for the HID input report builder.
// ----------------------------------------------------------------------------
package hirb_pkg;

    // event commands
    localparam logic [3:0] CMD_KEY_DN   = 4'd0;
    localparam logic [3:0] CMD_KEY_UP   = 4'd1;
    localparam logic [3:0] CMD_REL_MOVE = 4'd2;
    localparam logic [3:0] CMD_ABS_MOVE = 4'd3;
    localparam logic [3:0] CMD_BTN_DN   = 4'd4;
    localparam logic [3:0] CMD_BTN_UP   = 4'd5;
    localparam logic [3:0] CMD_ABTN_DN  = 4'd6;
    localparam logic [3:0] CMD_ABTN_UP  = 4'd7;
    localparam logic [3:0] CMD_WHEEL    = 4'd8;
    localparam logic [3:0] CMD_REL_ALL  = 4'd9;

    // report kinds, in the order release-all emits them
    localparam logic [1:0] KIND_KBD   = 2'd0;
    localparam logic [1:0] KIND_MOUSE = 2'd1;
    localparam logic [1:0] KIND_ABS   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_LINK_DOWN   = 2'd1;
    localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;

    localparam logic [2:0] BTN_LEFT   = 3'b001;
    localparam logic [2:0] BTN_RIGHT  = 3'b010;
    localparam logic [2:0] BTN_MIDDLE = 3'b100;

    localparam logic [15:0] ABS_MAX_RESET = 16'd32767;
    localparam logic [15:0] POS_RESET     = ABS_MAX_RESET / 16'd2;

    localparam int PACKED_SLOTS = 6;
    localparam int IN_DATA_W    = 112;
    localparam int OUT_DATA_W   = 128;

    typedef enum logic [3:0] {
        OP_ERR      = 4'd0,
        OP_KEY_DN   = 4'd1,
        OP_KEY_UP   = 4'd2,
        OP_REL_MOVE = 4'd3,
        OP_ABS_MOVE = 4'd4,
        OP_BTN_DN   = 4'd5,
        OP_BTN_UP   = 4'd6,
        OP_ABTN_DN  = 4'd7,
        OP_ABTN_UP  = 4'd8,
        OP_WHEEL    = 4'd9,
        OP_REL_ALL  = 4'd10
    } t_op_kind;

    // classified request, front end to back end
    typedef struct packed {
        t_op_kind    kind;
        logic [1:0]  status;
        logic [7:0]  usage;
        logic [7:0]  mods;
        logic [2:0]  btn;
        logic [7:0]  mx;
        logic [7:0]  my;
        logic [7:0]  wh;
        logic [7:0]  pn;
        logic [15:0] px;
        logic [15:0] py;
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [1:0]  status;
        logic [7:0]  mod_bits;
        logic [47:0] keys;
        logic [2:0]  button;
        logic [7:0]  mx;
        logic [7:0]  my;
        logic [7:0]  wh;
        logic [7:0]  pn;
        logic [15:0] px;
        logic [15:0] py;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_back_state;

endpackage

FILE: hw/rtl/hirb_front.sv
// ----------------------------------------------------------------------------
// hirb_front
// Accepts input events and classifies them into back-end requests.
// ----------------------------------------------------------------------------
module hirb_front
    import hirb_pkg::*;
(
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [3:0]           i_cmd,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic [15:0]          i_abs_max,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_op                  o_op
);

    logic [7:0]  w_usage;
    logic [7:0]  w_mods;
    logic [7:0]  w_btn_num;
    logic [15:0] w_dx;
    logic [15:0] w_dy;
    logic [15:0] w_tx;
    logic [15:0] w_ty;
    logic [7:0]  w_sv;
    logic [7:0]  w_sh;
    logic        w_link;
    t_op         w_op;

    function automatic logic [2:0] map_button(input logic [7:0] b);
        logic [2:0] m;
        m = BTN_LEFT;
        if (b == 8'd1) begin
            m = BTN_MIDDLE;
        end else if (b == 8'd2) begin
            m = BTN_RIGHT;
        end
        return m;
    endfunction

    function automatic logic [7:0] sat_move(input logic signed [15:0] v);
        logic [7:0] s;
        s = v[7:0];
        if (v > 16'sd127) begin
            s = 8'd127;
        end else if (v < -16'sd127) begin
            s = 8'h81;
        end
        return s;
    endfunction

    function automatic logic [15:0] clamp_pos(input logic [15:0] v, input logic [15:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    assign w_usage   = i_data[7:0];
    assign w_mods    = i_data[15:8];
    assign w_btn_num = i_data[23:16];
    assign w_dx      = i_data[39:24];
    assign w_dy      = i_data[55:40];
    assign w_tx      = i_data[71:56];
    assign w_ty      = i_data[87:72];
    assign w_sv      = i_data[95:88];
    assign w_sh      = i_data[103:96];
    assign w_link    = i_data[104];

    always_comb begin
        w_op        = '0;
        w_op.kind   = OP_ERR;
        w_op.status = STAT_OK;
        w_op.usage  = w_usage;
        w_op.mods   = w_mods;
        w_op.btn    = map_button(w_btn_num);
        if (!w_link) begin
            w_op.status = STAT_LINK_DOWN;
        end else begin
            unique case (i_cmd)
                CMD_KEY_DN:   w_op.kind = OP_KEY_DN;
                CMD_KEY_UP:   w_op.kind = OP_KEY_UP;
                CMD_REL_MOVE: begin
                    w_op.kind = OP_REL_MOVE;
                    w_op.mx   = sat_move(w_dx);
                    w_op.my   = sat_move(w_dy);
                end
                CMD_ABS_MOVE: begin
                    w_op.kind = OP_ABS_MOVE;
                    w_op.px   = clamp_pos(w_tx, i_abs_max);
                    w_op.py   = clamp_pos(w_ty, i_abs_max);
                end
                CMD_BTN_DN:   w_op.kind = OP_BTN_DN;
                CMD_BTN_UP:   w_op.kind = OP_BTN_UP;
                CMD_ABTN_DN:  w_op.kind = OP_ABTN_DN;
                CMD_ABTN_UP:  w_op.kind = OP_ABTN_UP;
                CMD_WHEEL: begin
                    w_op.kind = OP_WHEEL;
                    w_op.wh   = w_sv;
                    w_op.pn   = w_sh;
                end
                CMD_REL_ALL:  w_op.kind = OP_REL_ALL;
                default:      w_op.status = STAT_UNSUPPORTED;
            endcase
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_op    = w_op;

endmodule

FILE: hw/rtl/hirb_queue.sv
// ----------------------------------------------------------------------------
// hirb_queue
// Short request FIFO between front end and back end.
// ----------------------------------------------------------------------------
module hirb_queue
    import hirb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_op
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;

    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];

endmodule

FILE: hw/rtl/hirb_back.sv
// ----------------------------------------------------------------------------
// hirb_back
// Applies requests to the report state and emits report items.
// ----------------------------------------------------------------------------
module hirb_back
    import hirb_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_op  i_op,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    localparam int CW = $clog2(KEY_SLOTS + 1);
    localparam int PK = (KEY_SLOTS < PACKED_SLOTS) ? KEY_SLOTS : PACKED_SLOTS;

    t_back_state   r_state;
    t_op           r_op;
    logic [1:0]    r_sub;
    logic [7:0]    r_slots [KEY_SLOTS];
    logic [CW-1:0] r_count;
    logic [7:0]    r_mods;
    logic [2:0]    r_rel_btn;
    logic [2:0]    r_abs_btn;
    logic [15:0]   r_px;
    logic [15:0]   r_py;
    logic          r_out_valid;
    t_res          r_out;

    logic [7:0]    n_slots [KEY_SLOTS];
    logic [CW-1:0] n_count;
    logic [7:0]    n_mods;
    logic [2:0]    n_rel_btn;
    logic [2:0]    n_abs_btn;
    logic [15:0]   n_px;
    logic [15:0]   n_py;

    logic [7:0]    w_shift [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] w_hit;
    logic [KEY_SLOTS-1:0] w_after;
    logic          w_held;
    logic          w_run;
    logic          w_out_free;
    logic          w_emit;
    logic [1:0]    w_kind;
    logic          w_last;
    t_res          w_res;

    // key list lookup, only occupied slots
    always_comb begin
        w_run = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            w_hit[i] = (CW'(i) < r_count) && (r_slots[i] == i_op.usage);
        end
        for (int j = 0; j < KEY_SLOTS; j++) begin
            w_run      = w_run | w_hit[j];
            w_after[j] = w_run;
        end
        for (int j = 0; j < KEY_SLOTS - 1; j++) begin
            w_shift[j] = r_slots[j + 1];
        end
        w_shift[KEY_SLOTS-1] = '0;
    end

    assign w_held = |w_hit;

    always_comb begin
        n_slots   = r_slots;
        n_count   = r_count;
        n_mods    = r_mods;
        n_rel_btn = r_rel_btn;
        n_abs_btn = r_abs_btn;
        n_px      = r_px;
        n_py      = r_py;
        case (i_op.kind)
            OP_KEY_DN: begin
                if (i_op.mods != 8'd0) begin
                    n_mods = r_mods | i_op.mods;
                end else if (i_op.usage != 8'd0 && !w_held && r_count < CW'(KEY_SLOTS)) begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (CW'(i) == r_count) begin
                            n_slots[i] = i_op.usage;
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            OP_KEY_UP: begin
                if (i_op.mods != 8'd0) begin
                    n_mods = r_mods & ~i_op.mods;
                end else if (i_op.usage != 8'd0 && w_held) begin
                    // close the gap: slots from the match on move down by one
                    for (int j = 0; j < KEY_SLOTS; j++) begin
                        if (w_after[j]) begin
                            n_slots[j] = w_shift[j];
                        end
                    end
                    n_count = r_count - 1'b1;
                end
            end
            OP_ABS_MOVE: begin
                n_px = i_op.px;
                n_py = i_op.py;
            end
            OP_BTN_DN:  n_rel_btn = r_rel_btn | i_op.btn;
            OP_BTN_UP:  n_rel_btn = r_rel_btn & ~i_op.btn;
            OP_ABTN_DN: n_abs_btn = r_abs_btn | i_op.btn;
            OP_ABTN_UP: n_abs_btn = r_abs_btn & ~i_op.btn;
            OP_REL_ALL: begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    n_slots[i] = '0;
                end
                n_count   = '0;
                n_mods    = '0;
                n_rel_btn = '0;
                n_abs_btn = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_emit     = (r_state == ST_EMIT) && w_out_free;

    // report built from the already updated state
    always_comb begin
        w_kind = KIND_NONE;
        w_last = 1'b1;
        case (r_op.kind) inside
            OP_KEY_DN, OP_KEY_UP:                      w_kind = KIND_KBD;
            OP_REL_MOVE, OP_BTN_DN, OP_BTN_UP, OP_WHEEL: w_kind = KIND_MOUSE;
            OP_ABS_MOVE, OP_ABTN_DN, OP_ABTN_UP:       w_kind = KIND_ABS;
            OP_REL_ALL: begin
                // keyboard, mouse, pointer: the step count follows the kind codes
                w_kind = r_sub;
                w_last = (r_sub == KIND_ABS);
            end
            default:                                   w_kind = KIND_NONE;
        endcase
    end

    always_comb begin
        w_res      = '0;
        w_res.kind = w_kind;
        w_res.last = w_last;
        unique case (w_kind)
            KIND_KBD: begin
                w_res.mod_bits = r_mods;
                for (int i = 0; i < PK; i++) begin
                    w_res.keys[8*i +: 8] = r_slots[i];
                end
            end
            KIND_MOUSE: begin
                w_res.button = r_rel_btn;
                w_res.mx     = r_op.mx;
                w_res.my     = r_op.my;
                w_res.wh     = r_op.wh;
                w_res.pn     = r_op.pn;
            end
            KIND_ABS: begin
                w_res.button = r_abs_btn;
                w_res.px     = r_px;
                w_res.py     = r_py;
            end
            default: w_res.status = r_op.status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_mods      <= '0;
            r_rel_btn   <= '0;
            r_abs_btn   <= '0;
            r_px        <= POS_RESET;
            r_py        <= POS_RESET;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_slots[i] <= '0;
            end
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_slots   <= n_slots;
                        r_count   <= n_count;
                        r_mods    <= n_mods;
                        r_rel_btn <= n_rel_btn;
                        r_abs_btn <= n_abs_btn;
                        r_px      <= n_px;
                        r_py      <= n_py;
                        r_sub     <= '0;
                        r_state   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_sub <= r_sub + 1'b1;
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

FILE: hw/rtl/hid_input_report_builder.sv
// ----------------------------------------------------------------------------
// hid_input_report_builder
// Keyboard, relative-mouse and absolute-pointer HID report state and builder.
// ----------------------------------------------------------------------------
//  channel   | ports            | payload
//  ----------+------------------+-----------------------------------------------
//  event in  | i_s_axis_*       | tuser cmd, tdata event fields
//  report out| o_m_axis_*       | tuser report kind, tdata report, tlast last
//  config    | psel/penable/... | abs_max at byte address 0
//
//  In the back end a request is a state update followed by one report,
//  release-all a state update followed by three reports; the front end
//  enqueues one request a cycle while the request queue has room.
//  Reset is synchronous: abs_max returns to 32767, pointer to 16383, rest clear.
//  A stalled report holds in the output register while the queue keeps filling.
// ----------------------------------------------------------------------------
module hid_input_report_builder
    import hirb_pkg::*;
#(
    parameter int KEY_SLOTS   = 6,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // key_usage, mod_mask, button_number, rel_dx, rel_dy, target_x, target_y,
    // scroll_v, scroll_h, link_up, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // cmd
    input  logic [3:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status, mod_bits, keys_packed, button_bits, move_x, move_y, wheel_out,
    // pan_out, pos_x, pos_y, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // report_kind
    output logic [1:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic REG_ABS_MAX = 1'b0;

    logic [15:0] r_abs_max;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_op         w_front_op;
    t_op         w_back_op;
    t_res        w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_max <= ABS_MAX_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ABS_MAX) begin
            r_abs_max <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ABS_MAX) ? {16'd0, r_abs_max} : 32'd0;

    hirb_front u_front (
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_cmd     (i_s_axis_tuser),
        .i_data    (i_s_axis_tdata),
        .i_abs_max (r_abs_max),
        .i_q_full  (w_full),
        .o_push    (w_push),
        .o_op      (w_front_op)
    );

    hirb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_op    (w_back_op)
    );

    hirb_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_op    (w_back_op),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_res)
    );

    assign o_m_axis_tuser = w_res.kind;
    assign o_m_axis_tlast = w_res.last;
    assign o_m_axis_tdata = {3'd0, w_res.py, w_res.px, w_res.pn, w_res.wh, w_res.my,
                             w_res.mx, w_res.button, w_res.keys, w_res.mod_bits,
                             w_res.status};

endmodule

FILE: hw/rtl/hirb_checker.sv
// ----------------------------------------------------------------------------
// hirb_checker
// Port-level checks on the report stream, bound to the top level.
// ----------------------------------------------------------------------------
module hirb_checker
    import hirb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]            o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    // an error report is always the single result of its request
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_NONE
        |-> o_m_axis_tlast && o_m_axis_tdata[1:0] != STAT_OK)
        else $error("error report without status or not last");

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] != STAT_OK |-> o_m_axis_tuser == KIND_NONE)
        else $error("nonzero status on a real report");

    a_kbd_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_KBD |-> o_m_axis_tdata[57:2] == '0)
        else $error("keyboard fields set on another report kind");

    // only release-all gives a mouse report that is not last, and it is all clear
    a_rel_all_mouse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_MOUSE && !o_m_axis_tlast
        |-> o_m_axis_tdata[92:58] == '0)
        else $error("release-all mouse report not cleared");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled report changed");

endmodule

bind hid_input_report_builder hirb_checker u_hirb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
